### sv/sarf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sarf_pkg: shared types and constants
// Store geometry, kind codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package sarf_pkg;

  localparam int RING_DEPTH = 2048;
  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int PTR_W  = IDX_W + 1;
  localparam int FILL_W = 12;
  localparam int CNT_W  = 64;
  localparam int BLEN_W = 16;
  localparam int SAMP_W = 16;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  localparam logic [FILL_W-1:0] CEILING_RESET = 12'd2048;

  // Decoded command word held in the queue between front and back.
  typedef struct packed {
    logic                    is_write;
    logic                    is_read;
    logic                    is_discard;
    logic                    first;
    logic                    last;
    logic                    empty_call;
    logic [BLEN_W-1:0]       blen;
    logic [2*SAMP_W-1:0]     frame;   // left in low half, right in high half
  } cmd_t;

endpackage

`default_nettype wire

### sv/sarf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sarf interfaces: input, result and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sarf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic                                 first_of_burst;
  logic                                 last_of_burst;
  logic [sarf_pkg::BLEN_W-1:0]          burst_length;
  logic signed [sarf_pkg::SAMP_W-1:0]   left_in;
  logic signed [sarf_pkg::SAMP_W-1:0]   right_in;

  modport source (output valid, kind, first_of_burst, last_of_burst, burst_length,
                  left_in, right_in, input ready);
  modport sink   (input valid, kind, first_of_burst, last_of_burst, burst_length,
                  left_in, right_in, output ready);
endinterface

interface sarf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sarf_pkg::SAMP_W-1:0]   left_out;
  logic signed [sarf_pkg::SAMP_W-1:0]   right_out;
  logic                                 frame_from_store;
  logic                                 burst_accepted;
  logic                                 burst_silent;
  logic [sarf_pkg::FILL_W-1:0]          buffered_frames;
  logic [sarf_pkg::CNT_W-1:0]           enqueued_count;
  logic [sarf_pkg::CNT_W-1:0]           rendered_count;
  logic [sarf_pkg::CNT_W-1:0]           underrun_count;
  logic [sarf_pkg::CNT_W-1:0]           dropped_count;
  logic [sarf_pkg::CNT_W-1:0]           read_call_count;

  modport source (output valid, left_out, right_out, frame_from_store, burst_accepted,
                  burst_silent, buffered_frames, enqueued_count, rendered_count,
                  underrun_count, dropped_count, read_call_count, input ready);
  modport sink   (input valid, left_out, right_out, frame_from_store, burst_accepted,
                  burst_silent, buffered_frames, enqueued_count, rendered_count,
                  underrun_count, dropped_count, read_call_count, output ready);
endinterface

interface sarf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sarf_pkg::FILL_W-1:0]  backlog_ceiling;

  modport source (output valid, backlog_ceiling, input ready);
  modport sink   (input valid, backlog_ceiling, output ready);
endinterface

`default_nettype wire

### sv/sarf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sarf_front: input acceptance and decode
// Decodes each input word into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module sarf_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  sarf_in_if.sink              in_ch,
  output sarf_pkg::cmd_t       cmd,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready
);

  sarf_pkg::cmd_t q_r [2];
  logic           wr_sel_r, wr_sel_nxt;
  logic           rd_sel_r, rd_sel_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push, pop;
  sarf_pkg::cmd_t dec;

  assign in_ch.ready = rst_n && (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_sel_r];

  always_comb begin
    dec.is_write   = (in_ch.kind == sarf_pkg::KIND_WRITE);
    dec.is_read    = (in_ch.kind == sarf_pkg::KIND_READ);
    dec.is_discard = (in_ch.kind == sarf_pkg::KIND_DISCARD);
    dec.first      = in_ch.first_of_burst;
    dec.last       = in_ch.last_of_burst;
    dec.empty_call = in_ch.first_of_burst && (in_ch.burst_length == '0);
    dec.blen       = in_ch.burst_length;
    dec.frame      = {in_ch.right_in, in_ch.left_in};
  end

  always_comb begin
    wr_sel_nxt = push ? ~wr_sel_r : wr_sel_r;
    rd_sel_nxt = pop  ? ~rd_sel_r : rd_sel_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_sel_r <= wr_sel_nxt;
      rd_sel_r <= rd_sel_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_sel_r] <= dec;
    end
  end

endmodule

`default_nettype wire

### sv/sarf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sarf_back: command execution
// Owns the frame store, pointers, burst flags, totals and the result register.
// ----------------------------------------------------------------------------
module sarf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  sarf_pkg::cmd_t       cmd,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  sarf_cfg_if.sink             cfg_ch,
  sarf_out_if.source           out_ch
);

  localparam logic ST_EXEC   = 1'b0;
  localparam logic ST_RDWAIT = 1'b1;

  localparam logic [sarf_pkg::PTR_W-1:0] CAP = sarf_pkg::PTR_W'(sarf_pkg::RING_DEPTH);

  logic [2*sarf_pkg::SAMP_W-1:0] store_mem [sarf_pkg::RING_DEPTH];
  logic [2*sarf_pkg::SAMP_W-1:0] rdata_r;

  logic                          state_r, state_nxt;
  logic [sarf_pkg::PTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic                          ok_r, ok_nxt, got_r, got_nxt;
  logic [sarf_pkg::CNT_W-1:0]    enq_r, enq_nxt, rend_r, rend_nxt;
  logic [sarf_pkg::CNT_W-1:0]    und_r, und_nxt, drop_r, drop_nxt, calls_r, calls_nxt;
  logic [sarf_pkg::FILL_W-1:0]   ceil_r;
  logic                          out_valid_r, out_valid_nxt;

  logic                          out_free, exec;
  logic [sarf_pkg::PTR_W-1:0]    fill_raw, fill_c, avail, fill_after_raw;
  logic                          mem_we, mem_re;
  logic                          from_store, accepted, silent;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign cmd_ready = (state_r == ST_EXEC) && out_free;
  assign exec      = cmd_ready && cmd_valid;
  assign cfg_ch.ready = rst_n;

  always_comb begin
    fill_raw = wp_r - rp_r;
    fill_c   = (fill_raw > CAP) ? CAP : fill_raw;
    avail    = CAP - fill_c;

    wp_nxt = wp_r;  rp_nxt = rp_r;
    ok_nxt = ok_r;  got_nxt = got_r;
    enq_nxt = enq_r;  rend_nxt = rend_r;  und_nxt = und_r;
    drop_nxt = drop_r;  calls_nxt = calls_r;
    mem_we = 1'b0;  mem_re = 1'b0;
    from_store = 1'b0;  accepted = 1'b0;  silent = 1'b0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;

    unique case (state_r)
      ST_EXEC: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
        end
        if (exec) begin
          out_valid_nxt = 1'b1;
          if (cmd.is_write) begin
            if (cmd.first) begin
              if (cmd.empty_call) begin
                ok_nxt = 1'b0;
              end else if (fill_c >= ceil_r || cmd.blen > sarf_pkg::BLEN_W'(avail)) begin
                drop_nxt = drop_r + sarf_pkg::CNT_W'(cmd.blen);
                ok_nxt   = 1'b0;
              end else begin
                ok_nxt = 1'b1;
              end
            end
            if (ok_nxt && !cmd.empty_call && fill_c < CAP) begin
              mem_we  = 1'b1;
              wp_nxt  = wp_r + 1'b1;
              enq_nxt = enq_r + 1'b1;
            end
            accepted = ok_nxt;
          end else if (cmd.is_read) begin
            if (cmd.first) begin
              calls_nxt = calls_r + 1'b1;
              got_nxt   = 1'b0;
            end
            if (!cmd.empty_call) begin
              if (fill_c != '0) begin
                mem_re     = 1'b1;
                rp_nxt     = rp_r + 1'b1;
                rend_nxt   = rend_r + 1'b1;
                got_nxt    = 1'b1;
                from_store = 1'b1;
              end else begin
                und_nxt = und_r + 1'b1;
              end
            end
            silent = cmd.last && !got_nxt;
          end else if (cmd.is_discard) begin
            rp_nxt = wp_r;
          end
          // frame samples come from the registered store read, so wait in ST_RDWAIT
          if (mem_re) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EXEC;
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase

    fill_after_raw = wp_nxt - rp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      wp_r        <= '0;
      rp_r        <= '0;
      ok_r        <= 1'b0;
      got_r       <= 1'b0;
      enq_r       <= '0;
      rend_r      <= '0;
      und_r       <= '0;
      drop_r      <= '0;
      calls_r     <= '0;
      ceil_r      <= sarf_pkg::CEILING_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      ok_r        <= ok_nxt;
      got_r       <= got_nxt;
      enq_r       <= enq_nxt;
      rend_r      <= rend_nxt;
      und_r       <= und_nxt;
      drop_r      <= drop_nxt;
      calls_r     <= calls_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        ceil_r <= cfg_ch.backlog_ceiling;
      end
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wp_r[sarf_pkg::IDX_W-1:0]] <= cmd.frame;
    end
    if (mem_re) begin
      rdata_r <= store_mem[rp_r[sarf_pkg::IDX_W-1:0]];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      out_ch.left_out         <= '0;
      out_ch.right_out        <= '0;
      out_ch.frame_from_store <= from_store;
      out_ch.burst_accepted   <= accepted;
      out_ch.burst_silent     <= silent;
      out_ch.buffered_frames  <= sarf_pkg::FILL_W'((fill_after_raw > CAP) ? CAP
                                                                          : fill_after_raw);
      out_ch.enqueued_count   <= enq_nxt;
      out_ch.rendered_count   <= rend_nxt;
      out_ch.underrun_count   <= und_nxt;
      out_ch.dropped_count    <= drop_nxt;
      out_ch.read_call_count  <= calls_nxt;
    end else if (state_r == ST_RDWAIT) begin
      out_ch.left_out  <= rdata_r[sarf_pkg::SAMP_W-1:0];
      out_ch.right_out <= rdata_r[2*sarf_pkg::SAMP_W-1:sarf_pkg::SAMP_W];
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

### sv/stereo_audio_frame_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_audio_frame_ring: stereo frame FIFO with burst admission and totals
//
// in_ch carries one word per item: write frame, read frame, discard or no-op,
// with burst markers, burst length and the two samples of a written frame.
// out_ch returns exactly one result word per input word, in order: the frame
// read (zero when padded or not a read), burst flags, the fill after the item
// and the five 64-bit running totals.
// cfg_ch writes backlog_ceiling; it is ready whenever rst_n is high and
// should be used only while no item is in flight.
// Flow: a word accepted on in_ch waits in the command queue until the back
// end is free; the back end registers its result as it takes the word from
// the queue, and a read that takes a frame from the store waits in ST_RDWAIT
// for the registered read. Throughput: one word per cycle while out_ch does
// not stall; a read that takes a frame holds off the next word until it ends.
// Reset (rst_n low, synchronous): pointers, burst flags, totals and queue
// clear, backlog_ceiling returns to 2048, in_ch and cfg_ch are not ready.
// Store contents are not cleared.
// When out_ch stalls, the back end holds its result and stops; the two-entry
// command queue fills and then in_ch.ready drops.
// ----------------------------------------------------------------------------
module stereo_audio_frame_ring (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sarf_in_if.sink     in_ch,
  sarf_out_if.source  out_ch,
  sarf_cfg_if.sink    cfg_ch
);

  // decoded command word from the front queue to the back end
  sarf_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  // front: accept, classify, queue
  sarf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // back: pointers, store, totals, result register
  sarf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
